### rtl/p1305_pkg.sv
package p1305_pkg;

    localparam int LIMB_W     = 26;
    localparam int ACC_W      = 27;
    localparam int H_W        = 28;
    localparam int RS_W       = 29;
    localparam int PROD_W     = H_W + RS_W;
    localparam int D_W        = 60;
    localparam int NLIMB      = 5;
    localparam int LIMB_IDX_W = 3;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int KEY_W      = 64;
    localparam int TAG_W      = 128;
    localparam int BLK_BYTES  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_R_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_S_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_S_HIGH = 2'd3;

    localparam logic [LIMB_W-1:0] CLAMP0 = 26'h3ffffff;
    localparam logic [LIMB_W-1:0] CLAMP1 = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] CLAMP2 = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] CLAMP3 = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] CLAMP4 = 26'h00fffff;

    typedef logic [NLIMB-1:0][LIMB_W-1:0] r_limbs_t;

    typedef struct packed {
        logic                  vld;
        logic [LIMB_IDX_W-1:0] row;
        logic [PROD_W-1:0]     prod;
    } mul_out_t;

    typedef struct packed {
        logic             vld;
        logic [TAG_W-1:0] tag;
    } tag_beat_t;

    // Splits r into five limbs and applies the clamp.
    function automatic r_limbs_t clamp_r(input logic [KEY_W-1:0] lo,
                                         input logic [KEY_W-1:0] hi);
        logic [2*KEY_W-1:0] k;
        r_limbs_t           r;
        k    = {hi, lo};
        r[0] = k[25:0] & CLAMP0;
        r[1] = k[51:26] & CLAMP1;
        r[2] = k[77:52] & CLAMP2;
        r[3] = k[103:78] & CLAMP3;
        r[4] = {2'b00, k[127:104]} & CLAMP4;
        return r;
    endfunction

endpackage

### rtl/p1305_mul.sv
module p1305_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [p1305_pkg::LIMB_IDX_W-1:0]    row,
    input  logic [p1305_pkg::H_W-1:0]           a,
    input  logic [p1305_pkg::RS_W-1:0]          b,
    output p1305_pkg::mul_out_t                 q
);

    logic                              vld_reg;
    logic [p1305_pkg::LIMB_IDX_W-1:0]  row_reg;
    logic [p1305_pkg::PROD_W-1:0]      prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg  <= row;
            prod_reg <= p1305_pkg::PROD_W'(a) * p1305_pkg::PROD_W'(b);
        end
    end

    assign q.vld  = vld_reg;
    assign q.row  = row_reg;
    assign q.prod = prod_reg;

endmodule

### rtl/p1305_core.sv
module p1305_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                blk_valid,
    output logic                                blk_ready,
    input  logic [p1305_pkg::KEY_W-1:0]         block_low,
    input  logic [p1305_pkg::KEY_W-1:0]         block_high,
    input  logic [p1305_pkg::CNT_W-1:0]         byte_count,
    input  logic                                is_last,
    input  p1305_pkg::r_limbs_t                 r_limbs,
    input  logic [p1305_pkg::TAG_W-1:0]         s_key,
    input  logic                                tag_ready,
    output p1305_pkg::tag_beat_t                tag_out
);

    localparam int LW = p1305_pkg::LIMB_W;
    localparam int NL = p1305_pkg::NLIMB;
    localparam int IW = p1305_pkg::LIMB_IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_NORM  = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_FIN1  = 3'd5;
    localparam logic [2:0] S_FIN2  = 3'd6;

    localparam logic [IW-1:0] LAST_LIMB = IW'(NL - 1);
    localparam logic [3:0]    NORM_LAST = 4'(2 * NL - 1);

    logic [2:0]                        state_reg, state_next;
    logic [IW-1:0]                     i_reg, i_next, j_reg, j_next;
    logic [3:0]                        ncnt_reg, ncnt_next;
    logic                              last_reg, last_next;
    logic [p1305_pkg::ACC_W-1:0]       acc_reg [NL];
    logic [p1305_pkg::ACC_W-1:0]       acc_next [NL];
    logic [p1305_pkg::H_W-1:0]         h_reg [NL];
    logic [p1305_pkg::H_W-1:0]         h_next [NL];
    logic [p1305_pkg::D_W-1:0]         d_reg [NL];
    logic [p1305_pkg::D_W-1:0]         d_next [NL];
    logic [127:0]                      fin_reg, fin_next;

    logic [p1305_pkg::CNT_W-1:0]       n_sat;
    logic                              full;
    logic [127:0]                      blk;
    logic [127:0]                      m;
    logic [p1305_pkg::H_W-1:0]         h_in [NL];

    logic                              wrap;
    logic [IW-1:0]                     ridx;
    logic [LW-1:0]                     rsel;
    logic [p1305_pkg::RS_W-1:0]        mul_b;
    p1305_pkg::mul_out_t               mq;

    logic [IW-1:0]                     k;
    logic [p1305_pkg::D_W-LW-1:0]      carry;
    logic [p1305_pkg::D_W-1:0]         carry_x;
    logic [129:0]                      hval;
    logic [130:0]                      gval;

    // Block padding and the add into the accumulator.
    always_comb
    begin
        n_sat = (byte_count > p1305_pkg::CNT_W'(p1305_pkg::BLK_BYTES))
              ? p1305_pkg::CNT_W'(p1305_pkg::BLK_BYTES) : byte_count;
        full  = !is_last || (n_sat == p1305_pkg::CNT_W'(p1305_pkg::BLK_BYTES));
        blk   = {block_high, block_low};
        for (int b = 0; b < p1305_pkg::BLK_BYTES; b++)
        begin
            if (full || (p1305_pkg::CNT_W'(b) < n_sat))
            begin
                m[8*b +: 8] = blk[8*b +: 8];
            end
            else if (p1305_pkg::CNT_W'(b) == n_sat)
            begin
                m[8*b +: 8] = 8'h01;
            end
            else
            begin
                m[8*b +: 8] = 8'h00;
            end
        end
        for (int l = 0; l < NL - 1; l++)
        begin
            h_in[l] = p1305_pkg::H_W'(acc_reg[l]) + p1305_pkg::H_W'(m[LW*l +: LW]);
        end
        h_in[NL-1] = p1305_pkg::H_W'(acc_reg[NL-1]) + p1305_pkg::H_W'({full, m[127:104]});
    end

    // Operand selection for the shared multiplier; wrapped terms use 5*r.
    always_comb
    begin
        wrap  = j_reg > i_reg;
        ridx  = wrap ? IW'(i_reg + IW'(NL) - j_reg) : IW'(i_reg - j_reg);
        rsel  = r_limbs[ridx];
        mul_b = wrap ? ((p1305_pkg::RS_W'(rsel) << 2) + p1305_pkg::RS_W'(rsel))
                     : p1305_pkg::RS_W'(rsel);
    end

    p1305_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (state_reg == S_MAC),
        .row   (i_reg),
        .a     (h_reg[j_reg]),
        .b     (mul_b),
        .q     (mq)
    );

    always_comb
    begin
        k       = (ncnt_reg < 4'(NL)) ? ncnt_reg[IW-1:0] : IW'(ncnt_reg - 4'(NL));
        carry   = d_reg[k][p1305_pkg::D_W-1:LW];
        carry_x = p1305_pkg::D_W'(carry);
        hval    = {acc_reg[4][LW-1:0], acc_reg[3][LW-1:0], acc_reg[2][LW-1:0],
                   acc_reg[1][LW-1:0], acc_reg[0][LW-1:0]};
        gval    = {1'b0, hval} + 131'd5;

        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ncnt_next  = ncnt_reg;
        last_next  = last_reg;
        acc_next   = acc_reg;
        h_next     = h_reg;
        d_next     = d_reg;
        fin_next   = fin_reg;
        tag_out.vld = 1'b0;
        tag_out.tag = fin_reg + s_key;

        if (mq.vld)
        begin
            d_next[mq.row] = d_reg[mq.row] + p1305_pkg::D_W'(mq.prod);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (blk_valid)
                begin
                    last_next = is_last;
                    if (is_last && (n_sat == '0))
                    begin
                        state_next = S_FIN1;
                    end
                    else
                    begin
                        h_next = h_in;
                        for (int l = 0; l < NL; l++)
                        begin
                            d_next[l] = '0;
                        end
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                if (j_reg == LAST_LIMB)
                begin
                    j_next = '0;
                    if (i_reg == LAST_LIMB)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                ncnt_next  = '0;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                // One carry step per cycle; the top carry folds back times five.
                d_next[k] = p1305_pkg::D_W'(d_reg[k][LW-1:0]);
                if (k == LAST_LIMB)
                begin
                    d_next[0] = d_reg[0] + (carry_x << 2) + carry_x;
                end
                else
                begin
                    d_next[IW'(k + 1'b1)] = d_reg[IW'(k + 1'b1)] + carry_x;
                end
                if (ncnt_reg == NORM_LAST)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    ncnt_next = ncnt_reg + 1'b1;
                end
            end
            S_STORE:
            begin
                for (int l = 0; l < NL; l++)
                begin
                    acc_next[l] = d_reg[l][p1305_pkg::ACC_W-1:0];
                end
                state_next = last_reg ? S_FIN1 : S_IDLE;
            end
            S_FIN1:
            begin
                // If h + 5 reaches 2^130 then h is at least p; take h - p.
                fin_next   = gval[130] ? gval[127:0] : hval[127:0];
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                tag_out.vld = 1'b1;
                if (tag_ready)
                begin
                    for (int l = 0; l < NL; l++)
                    begin
                        acc_next[l] = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign blk_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            ncnt_reg  <= '0;
            last_reg  <= 1'b0;
            for (int l = 0; l < NL; l++)
            begin
                acc_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ncnt_reg  <= ncnt_next;
            last_reg  <= last_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        d_reg   <= d_next;
        fin_reg <= fin_next;
    end

endmodule

### rtl/poly1305_mac_engine_top.sv
// Poly1305 authenticator engine, one 16-byte block per input beat. Each block runs
// 25 limb products on one shared 28x29-bit multiplier, a drain state, 10 carry steps,
// a store state and the idle state that takes the next beat.
// A last beat then passes through final reduction and the s add (a last beat with no
// bytes goes straight to them); its tag waits while the output holds a stalled tag.
// Reset clears the key registers, the accumulator and the output valid.
module poly1305_mac_engine_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [p1305_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [p1305_pkg::KEY_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [p1305_pkg::KEY_W-1:0]          block_low,
    input  logic [p1305_pkg::KEY_W-1:0]          block_high,
    input  logic [p1305_pkg::CNT_W-1:0]          byte_count,
    input  logic                                 is_last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [p1305_pkg::KEY_W-1:0]          tag_low,
    output logic [p1305_pkg::KEY_W-1:0]          tag_high
);

    logic [p1305_pkg::KEY_W-1:0]  r_low_reg, r_high_reg, s_low_reg, s_high_reg;
    logic                         out_vld_reg;
    logic [p1305_pkg::TAG_W-1:0]  tag_reg;
    logic                         blk_ready;
    logic                         tag_ready;
    p1305_pkg::tag_beat_t         tag_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_low_reg  <= '0;
            r_high_reg <= '0;
            s_low_reg  <= '0;
            s_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                p1305_pkg::REG_R_LOW:  r_low_reg  <= cfg_data;
                p1305_pkg::REG_R_HIGH: r_high_reg <= cfg_data;
                p1305_pkg::REG_S_LOW:  s_low_reg  <= cfg_data;
                p1305_pkg::REG_S_HIGH: s_high_reg <= cfg_data;
                default:               r_low_reg  <= r_low_reg;
            endcase
        end
    end

    p1305_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_valid  (in_valid),
        .blk_ready  (blk_ready),
        .block_low  (block_low),
        .block_high (block_high),
        .byte_count (byte_count),
        .is_last    (is_last),
        .r_limbs    (p1305_pkg::clamp_r(r_low_reg, r_high_reg)),
        .s_key      ({s_high_reg, s_low_reg}),
        .tag_ready  (tag_ready),
        .tag_out    (tag_beat)
    );

    assign in_stall  = !blk_ready;
    assign tag_ready = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (tag_beat.vld && tag_ready)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_beat.vld && tag_ready)
        begin
            tag_reg <= tag_beat.tag;
        end
    end

    assign out_valid = out_vld_reg;
    assign tag_low   = tag_reg[p1305_pkg::KEY_W-1:0];
    assign tag_high  = tag_reg[p1305_pkg::TAG_W-1:p1305_pkg::KEY_W];

endmodule
